FILE: rtl/core/c2c_pkg.sv
// Shared types and constants for the coordinate-to-CSR table builder.
package c2c_pkg;

  // Default sizes
  localparam int unsigned MAX_ROWS_DEF    = 1024;
  localparam int unsigned MAX_ENTRIES_DEF = 4096;
  localparam int unsigned INDEX_WIDTH_DEF = 24;

  // Command codes
  typedef enum logic [2:0] {
    OP_COUNT    = 3'd0,
    OP_FINISH   = 3'd1,
    OP_PLACE    = 3'd2,
    OP_READ_PTR = 3'd3,
    OP_READ_ENT = 3'd4,
    OP_CLEAR    = 3'd5
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DROPPED = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_RANGE   = 2'd3
  } status_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_ROW_START  = 2'd0,
    REG_NUM_ROWS   = 2'd1,
    REG_STRUCTURE  = 2'd2,
    REG_VALUE_KIND = 2'd3
  } reg_idx_t;

  // Structure modes
  localparam logic [1:0] MODE_SYMMETRIC = 2'd1;
  localparam logic [1:0] MODE_HERMITIAN = 2'd2;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [24:0] row_index;
    logic [24:0] col_index;
    logic [63:0] value_real;
    logic [63:0] value_imag;
  } in_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [23:0] result_word;
    logic [63:0] result_real;
    logic [63:0] result_imag;
  } out_res_t;

endpackage

FILE: rtl/core/coo_to_csr_builder.sv
// Coordinate-to-CSR table builder: counters, pointers and entry stores in on-chip memories.
//
//  channel | ports                          | handshake
//  --------+--------------------------------+----------------------------------
//  request | start, busy, in_req            | taken when start and !busy
//  result  | out_valid, out_data            | one-cycle strobe, no back-pressure
//  config  | cfg_we, cfg_index, cfg_data    | written when cfg_we is high
//
// One request at a time. Place reads the row pointers and the fill counter, then writes the fill
// counter back, once per stored copy. Finish walks the local rows, one pointer per cycle,
// then sweeps all MAX_ROWS fill counters. Clear sweeps MAX_ROWS + 1 entries.
// After reset a clearing pass over the pointer and fill memories holds busy high.
// The result leaves in the cycle after the request completes; the receiver cannot stall.
module coo_to_csr_builder
  import c2c_pkg::*;
#(
  parameter int unsigned MAX_ROWS    = MAX_ROWS_DEF,
  parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int unsigned INDEX_WIDTH = INDEX_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_req_t     in_req,
  output logic        out_valid,
  output out_res_t    out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  localparam int unsigned RP_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS + 1) : 1;
  localparam int unsigned FC_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned EA_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [11:0] {
    S_CLR    = 12'b0000_0000_0001,
    S_IDLE   = 12'b0000_0000_0010,
    S_DEC    = 12'b0000_0000_0100,
    S_CNT_WR = 12'b0000_0000_1000,
    S_FIN_WR = 12'b0000_0001_0000,
    S_FCLR   = 12'b0000_0010_0000,
    S_PL_LO  = 12'b0000_0100_0000,
    S_PL_HI  = 12'b0000_1000_0000,
    S_PL_WM  = 12'b0001_0000_0000,
    S_PL_WD  = 12'b0010_0000_0000,
    S_RD_WT  = 12'b0100_0000_0000,
    S_SPARE  = 12'b1000_0000_0000
  } state_t;

  typedef enum logic {
    PH_COUNT = 1'b0,
    PH_PLACE = 1'b1
  } phase_t;

  // Configuration registers
  logic [23:0] row_start_r;
  logic [10:0] num_rows_r;
  logic [1:0]  mode_r;
  logic        vkind_r;

  // Control and working registers
  state_t                state_r, state_nxt;
  phase_t                phase_r, phase_nxt;
  logic [RP_AW-1:0]      idx_r, idx_nxt;
  logic [CNT_W-1:0]      run_r, run_nxt;
  logic [CNT_W-1:0]      total_r, total_nxt;
  logic                  clr_out_r, clr_out_nxt;
  logic                  pl_dir_r, pl_dir_nxt;
  in_req_t               req_r;
  logic [CNT_W-1:0]      base_r, base_nxt;
  logic [CNT_W-1:0]      fill_r, fill_nxt;
  logic [EA_W-1:0]       m_slot_r, m_slot_nxt, d_slot_r, d_slot_nxt;
  logic [CNT_W-1:0]      m_fill_r, m_fill_nxt, d_fill_r, d_fill_nxt;
  logic                  out_valid_r;
  out_res_t              out_data_r;

  // Memories
  logic [CNT_W-1:0]       rp_mem [MAX_ROWS+1];
  logic [CNT_W-1:0]       fc_mem [MAX_ROWS];
  logic [INDEX_WIDTH-1:0] col_mem [MAX_ENTRIES];
  logic [63:0]            re_mem [MAX_ENTRIES];
  logic [63:0]            im_mem [MAX_ENTRIES];

  logic                   rp_we, fc_we, st_we;
  logic [RP_AW-1:0]       rp_raddr, rp_waddr;
  logic [FC_AW-1:0]       fc_raddr, fc_waddr;
  logic [EA_W-1:0]        st_raddr, st_waddr;
  logic [CNT_W-1:0]       rp_wdata, fc_wdata, rp_q, fc_q;
  logic [INDEX_WIDTH-1:0] st_wcol, col_q;
  logic [63:0]            st_wre, st_wim, re_q, im_q;

  logic     done;
  out_res_t res;

  // Entry decode
  logic [RP_AW-1:0]  n_used;
  logic              mirror, dr, mr;
  logic [24:0]       r_g, c_g, r_off, c_off;
  logic [FC_AW-1:0]  ri, ci, cur_row;
  logic [1:0]        k;
  logic [CNT_W:0]    cnt_sum, slot_sum;
  logic [32:0]       r_m1, c_m1;
  logic [63:0]       imv;

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Window decode of both coordinates
  always_comb begin
    n_used = (num_rows_r > MAX_ROWS) ? RP_AW'(MAX_ROWS) : RP_AW'(num_rows_r);
    mirror = ((mode_r == MODE_SYMMETRIC) || (mode_r == MODE_HERMITIAN)) &&
             (req_r.row_index != req_r.col_index);
    r_g    = req_r.row_index - 25'd1;
    c_g    = req_r.col_index - 25'd1;
    r_off  = r_g - {1'b0, row_start_r};
    c_off  = c_g - {1'b0, row_start_r};
    dr     = (req_r.row_index != 25'd0) && (r_g >= {1'b0, row_start_r}) &&
             (r_off < {{(25 > RP_AW ? 25 - RP_AW : 0){1'b0}}, n_used});
    mr     = mirror && (req_r.col_index != 25'd0) && (c_g >= {1'b0, row_start_r}) &&
             (c_off < {{(25 > RP_AW ? 25 - RP_AW : 0){1'b0}}, n_used});
    ri     = r_off[FC_AW-1:0];
    ci     = c_off[FC_AW-1:0];
    cur_row = pl_dir_r ? ri : ci;
    k      = {1'b0, dr} + {1'b0, mr};
    cnt_sum  = {1'b0, total_r} + (CNT_W+1)'(k);
    slot_sum = {1'b0, base_r} + {1'b0, fill_r};
    r_m1   = {8'd0, req_r.row_index} - 33'd1;
    c_m1   = {8'd0, req_r.col_index} - 33'd1;
    imv    = vkind_r ? req_r.value_imag : 64'd0;
  end

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    phase_nxt   = phase_r;
    idx_nxt     = idx_r;
    run_nxt     = run_r;
    total_nxt   = total_r;
    clr_out_nxt = clr_out_r;
    pl_dir_nxt  = pl_dir_r;
    base_nxt    = base_r;
    fill_nxt    = fill_r;
    m_slot_nxt  = m_slot_r;
    m_fill_nxt  = m_fill_r;
    d_slot_nxt  = d_slot_r;
    d_fill_nxt  = d_fill_r;
    rp_we = 1'b0; rp_raddr = '0; rp_waddr = '0; rp_wdata = '0;
    fc_we = 1'b0; fc_raddr = '0; fc_waddr = '0; fc_wdata = '0;
    st_we = 1'b0; st_raddr = '0; st_waddr = '0;
    st_wcol = '0; st_wre = '0; st_wim = '0;
    done = 1'b0;
    res  = '0;

    unique case (state_r)
      S_CLR: begin
        rp_we    = 1'b1;
        rp_waddr = idx_r;
        fc_we    = (idx_r < RP_AW'(MAX_ROWS));
        fc_waddr = idx_r[FC_AW-1:0];
        if (idx_r == RP_AW'(MAX_ROWS)) begin
          idx_nxt   = '0;
          phase_nxt = PH_COUNT;
          total_nxt = '0;
          done      = clr_out_r;
          clr_out_nxt = 1'b0;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + RP_AW'(1);
        end
      end

      S_IDLE: begin
        if (start) state_nxt = S_DEC;
      end

      S_DEC: begin
        unique case (req_r.opcode)
          OP_COUNT: begin
            res.result_word = 24'(total_r);
            if (phase_r != PH_COUNT || k == 2'd0) begin
              res.status = ST_DROPPED;
              done = 1'b1; state_nxt = S_IDLE;
            end else if (cnt_sum > (CNT_W+1)'(MAX_ENTRIES)) begin
              res.status = ST_OVERFLOW;
              done = 1'b1; state_nxt = S_IDLE;
            end else begin
              rp_raddr  = RP_AW'(ri) + RP_AW'(1);
              fc_raddr  = ci;
              state_nxt = S_CNT_WR;
            end
          end
          OP_FINISH: begin
            idx_nxt = '0;
            run_nxt = '0;
            if (phase_r == PH_COUNT && n_used != '0) begin
              rp_raddr  = RP_AW'(1);
              fc_raddr  = '0;
              state_nxt = S_FIN_WR;
            end else begin
              if (phase_r == PH_COUNT) total_nxt = '0;
              phase_nxt = PH_PLACE;
              state_nxt = S_FCLR;
            end
          end
          OP_PLACE: begin
            res.result_word = 24'(total_r);
            if (phase_r != PH_PLACE || (!dr && !mr)) begin
              res.status = ST_DROPPED;
              done = 1'b1; state_nxt = S_IDLE;
            end else begin
              pl_dir_nxt = !mr;
              rp_raddr   = RP_AW'(mr ? ci : ri);
              fc_raddr   = mr ? ci : ri;
              state_nxt  = S_PL_LO;
            end
          end
          OP_READ_PTR: begin
            if (req_r.row_index <= 25'(n_used)) begin
              rp_raddr  = req_r.row_index[RP_AW-1:0];
              state_nxt = S_RD_WT;
            end else begin
              res.status = ST_RANGE;
              done = 1'b1; state_nxt = S_IDLE;
            end
          end
          OP_READ_ENT: begin
            if (phase_r == PH_PLACE && req_r.row_index < 25'(total_r) &&
                req_r.row_index < 25'(MAX_ENTRIES)) begin
              st_raddr  = req_r.row_index[EA_W-1:0];
              state_nxt = S_RD_WT;
            end else begin
              res.status = ST_RANGE;
              done = 1'b1; state_nxt = S_IDLE;
            end
          end
          OP_CLEAR: begin
            idx_nxt     = '0;
            clr_out_nxt = 1'b1;
            state_nxt   = S_CLR;
          end
          default: begin
            done = 1'b1; state_nxt = S_IDLE;
          end
        endcase
      end

      // Bump the row and mirror counters read in the decode cycle
      S_CNT_WR: begin
        rp_we    = dr;
        rp_waddr = RP_AW'(ri) + RP_AW'(1);
        rp_wdata = rp_q + CNT_W'(1);
        fc_we    = mr;
        fc_waddr = ci;
        fc_wdata = fc_q + CNT_W'(1);
        total_nxt = cnt_sum[CNT_W-1:0];
        res.result_word = 24'(cnt_sum[CNT_W-1:0]);
        done = 1'b1; state_nxt = S_IDLE;
      end

      // Prefix sum: one row per cycle, next read issued alongside the write
      S_FIN_WR: begin
        run_nxt  = run_r + rp_q + fc_q;
        rp_we    = 1'b1;
        rp_waddr = idx_r + RP_AW'(1);
        rp_wdata = run_nxt;
        rp_raddr = idx_r + RP_AW'(2);
        fc_raddr = FC_AW'(idx_r + RP_AW'(1));
        if (idx_r + RP_AW'(1) == n_used) begin
          total_nxt = run_nxt;
          phase_nxt = PH_PLACE;
          idx_nxt   = '0;
          state_nxt = S_FCLR;
        end else begin
          idx_nxt = idx_r + RP_AW'(1);
        end
      end

      // Sweep every fill counter to zero
      S_FCLR: begin
        fc_we    = 1'b1;
        fc_waddr = idx_r[FC_AW-1:0];
        if (idx_r == RP_AW'(MAX_ROWS - 1)) begin
          idx_nxt = '0;
          res.result_word = 24'(total_r);
          done = 1'b1; state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + RP_AW'(1);
        end
      end

      // Capture row base and fill, fetch the next row pointer
      S_PL_LO: begin
        base_nxt  = rp_q;
        fill_nxt  = fc_q;
        rp_raddr  = RP_AW'(cur_row) + RP_AW'(1);
        state_nxt = S_PL_HI;
      end

      // Check room in the row under test
      S_PL_HI: begin
        res.result_word = 24'(total_r);
        if (slot_sum >= {1'b0, rp_q} || slot_sum >= (CNT_W+1)'(MAX_ENTRIES)) begin
          res.status = ST_OVERFLOW;
          done = 1'b1; state_nxt = S_IDLE;
        end else if (!pl_dir_r) begin
          m_slot_nxt = EA_W'(slot_sum);
          m_fill_nxt = fill_r;
          if (dr) begin
            pl_dir_nxt = 1'b1;
            rp_raddr   = RP_AW'(ri);
            fc_raddr   = ri;
            state_nxt  = S_PL_LO;
          end else begin
            state_nxt = S_PL_WM;
          end
        end else begin
          d_slot_nxt = EA_W'(slot_sum);
          d_fill_nxt = fill_r;
          state_nxt  = mr ? S_PL_WM : S_PL_WD;
        end
      end

      // Store the mirrored copy
      S_PL_WM: begin
        st_we    = 1'b1;
        st_waddr = m_slot_r;
        st_wcol  = INDEX_WIDTH'(r_m1);
        st_wre   = req_r.value_real;
        st_wim   = imv;
        fc_we    = 1'b1;
        fc_waddr = ci;
        fc_wdata = m_fill_r + CNT_W'(1);
        if (dr) begin
          state_nxt = S_PL_WD;
        end else begin
          res.result_word = 24'(total_r);
          done = 1'b1; state_nxt = S_IDLE;
        end
      end

      // Store the direct copy, conjugated in Hermitian mode
      S_PL_WD: begin
        st_we    = 1'b1;
        st_waddr = d_slot_r;
        st_wcol  = INDEX_WIDTH'(c_m1);
        st_wre   = req_r.value_real;
        st_wim   = (vkind_r && mode_r == MODE_HERMITIAN) ? {~imv[63], imv[62:0]} : imv;
        fc_we    = 1'b1;
        fc_waddr = ri;
        fc_wdata = d_fill_r + CNT_W'(1);
        res.result_word = 24'(total_r);
        done = 1'b1; state_nxt = S_IDLE;
      end

      S_RD_WT: begin
        if (req_r.opcode == OP_READ_PTR) begin
          res.result_word = 24'(rp_q);
        end else begin
          res.result_word = 24'(col_q);
          res.result_real = re_q;
          res.result_imag = im_q;
        end
        done = 1'b1; state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      phase_r     <= PH_COUNT;
      idx_r       <= '0;
      run_r       <= '0;
      total_r     <= '0;
      clr_out_r   <= 1'b0;
      pl_dir_r    <= 1'b0;
      out_valid_r <= 1'b0;
      row_start_r <= '0;
      num_rows_r  <= 11'd1;
      mode_r      <= '0;
      vkind_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      idx_r       <= idx_nxt;
      run_r       <= run_nxt;
      total_r     <= total_nxt;
      clr_out_r   <= clr_out_nxt;
      pl_dir_r    <= pl_dir_nxt;
      out_valid_r <= done;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ROW_START:  row_start_r <= cfg_data;
          REG_NUM_ROWS:   num_rows_r  <= cfg_data[10:0];
          REG_STRUCTURE:  mode_r      <= cfg_data[1:0];
          REG_VALUE_KIND: vkind_r     <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (start && !busy) req_r <= in_req;
    base_r   <= base_nxt;
    fill_r   <= fill_nxt;
    m_slot_r <= m_slot_nxt;
    m_fill_r <= m_fill_nxt;
    d_slot_r <= d_slot_nxt;
    d_fill_r <= d_fill_nxt;
    if (done) out_data_r <= res;
  end

  // Row pointer memory
  always_ff @(posedge clk) begin
    if (rp_we) rp_mem[rp_waddr] <= rp_wdata;
    rp_q <= rp_mem[rp_raddr];
  end

  // Fill / mirror count memory
  always_ff @(posedge clk) begin
    if (fc_we) fc_mem[fc_waddr] <= fc_wdata;
    fc_q <= fc_mem[fc_raddr];
  end

  // Entry stores
  always_ff @(posedge clk) begin
    if (st_we) begin
      col_mem[st_waddr] <= st_wcol;
      re_mem[st_waddr]  <= st_wre;
      im_mem[st_waddr]  <= st_wim;
    end
    col_q <= col_mem[st_raddr];
    re_q  <= re_mem[st_raddr];
    im_q  <= im_mem[st_raddr];
  end

  // Checks
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(busy))
    else $error("result strobe without work");

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= CNT_W'(MAX_ENTRIES))
    else $error("entry total above capacity");

  a_prefix_in_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN_WR) |-> (phase_r == PH_COUNT))
    else $error("prefix walk outside count phase");

endmodule
